@@ rtl/core/searchable_fifo_queue_macros.svh @@
// ============================================================================
// Assertion macros for the searchable FIFO queue
// Shared helpers that keep every concurrent check in one uniform form.
// ============================================================================
`ifndef SEARCHABLE_FIFO_QUEUE_MACROS_SVH
`define SEARCHABLE_FIFO_QUEUE_MACROS_SVH

// Check that is muted while the reset is asserted.
`define SFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset, for reset behavior itself.
`define SFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sfq_pkg.sv @@
// ============================================================================
// Searchable FIFO queue package
// Request kinds, status codes and controller states shared by the design.
// ============================================================================
`timescale 1ns / 1ps

package sfq_pkg;

    // Request kinds carried in the input tuser field.
    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_FIND   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    // Result status codes carried in the output tuser field.
    typedef enum logic [1:0] {
        STS_DONE     = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIND = 1'b1
    } t_state;

    // Field widths of one transfer.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int FPOS_W  = 7;
    localparam int CNT_W   = 7;

    // Position reported when no entry matches.
    localparam logic [FPOS_W-1:0] NONE_POS = 7'h7F;

endpackage

@@ rtl/core/searchable_fifo_queue.sv @@
// ============================================================================
// Searchable FIFO queue
// Circular-buffer FIFO of unsigned 32-bit values with push, pop, update,
// find and clear requests; one result transfer per request.
// ============================================================================
//
//  Channel   Direction  tdata (low bit up)              tuser
//  --------  ---------  ------------------------------  ------------
//  s (req)   in         value[31:0], position[37:32]    req_type[2:0]
//  m (res)   out        found_pos[6:0], entry_count     status[1:0]
//
//  Push, pop, update, clear and unknown kinds are handled in the accept
//  cycle: the entry RAM is written then and the result is registered.
//  Find walks the stored entries through the RAM read port, one entry per
//  cycle, and compares each registered read word with the search key.
//  Reset is synchronous and active low; it empties the queue, no clearing
//  pass is run. A stalled result holds; a new request is taken in the
//  cycle the pending result is transferred.
//
`timescale 1ns / 1ps

module searchable_fifo_queue
    import sfq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // value[31:0], position[37:32], zero pad
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // found_pos[6:0], entry_count[13:7], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // Slot at an offset from a base, wrapped once (both below DEPTH).
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW:0] sum;
        sum = (SW+1)'(base) + (SW+1)'(off);
        if (sum >= (SW+1)'(DEPTH)) begin
            sum = sum - (SW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_occ, n_occ;
    logic [VALUE_W-1:0]    r_key, n_key;
    logic [CW-1:0]         r_scan, n_scan;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_out_vld, n_out_vld;
    t_status               r_out_sts, n_out_sts;
    logic [FPOS_W-1:0]     r_out_fpos, n_out_fpos;
    logic [CNT_W-1:0]      r_out_cnt, n_out_cnt;

    logic                  w_acc;
    logic [VALUE_W-1:0]    w_value;
    logic [POS_W-1:0]      w_pos;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [VALUE_W-1:0]    w_rdata;
    logic [CW-1:0]         w_upd_off;

    assign w_value = i_s_tdata[31:0];
    assign w_pos   = i_s_tdata[37:32];

    // Requests are held off while a find owns the read port or a result is stalled.
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_vld || i_m_tready);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Update target: position from the head, or the tail entry past the end.
    assign w_upd_off = (XW'(w_pos) < XW'(r_occ)) ? CW'(w_pos) : (r_occ - CW'(1));

    sfq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_value),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Next state, RAM control and result loading.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_key      = r_key;
        n_scan     = r_scan;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_out_vld  = r_out_vld;
        n_out_sts  = r_out_sts;
        n_out_fpos = r_out_fpos;
        n_out_cnt  = r_out_cnt;
        w_we       = 1'b0;
        w_waddr    = r_tail;
        w_re       = 1'b0;
        w_raddr    = slot_add(r_head, r_scan);

        // The pending result leaves on its transfer.
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out_vld  = 1'b1;
                    n_out_sts  = STS_DONE;
                    n_out_fpos = NONE_POS;
                    case (i_s_tuser)
                        REQ_PUSH: begin
                            if (r_occ >= CW'(DEPTH)) begin
                                n_out_sts = STS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_tail;
                                n_tail  = slot_add(r_tail, CW'(1));
                                n_occ   = r_occ + CW'(1);
                            end
                        end
                        REQ_POP: begin
                            if (r_occ == '0) begin
                                n_out_sts = STS_EMPTY;
                            end else begin
                                n_occ  = r_occ - CW'(1);
                                n_head = (r_occ == CW'(1)) ? r_tail
                                                           : slot_add(r_head, CW'(1));
                            end
                        end
                        REQ_UPDATE: begin
                            if (r_occ == '0) begin
                                n_out_sts = STS_EMPTY;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = slot_add(r_head, w_upd_off);
                            end
                        end
                        REQ_FIND: begin
                            n_out_vld = 1'b0;
                            n_state   = S_FIND;
                            n_key     = w_value;
                            n_scan    = '0;
                            n_cmp_vld = 1'b0;
                        end
                        REQ_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                            n_occ  = '0;
                        end
                        default: begin
                            // Unknown kinds leave the queue as it is.
                        end
                    endcase
                    n_out_cnt = CNT_W'(n_occ);
                end
            end
            S_FIND: begin
                // Issue one read per cycle; compare the data in the cycle after its read.
                w_re      = (r_scan < r_occ);
                n_cmp_vld = w_re;
                n_cmp_idx = r_scan;
                if (w_re) begin
                    n_scan = r_scan + CW'(1);
                end
                if (r_cmp_vld && (w_rdata == r_key)) begin
                    n_state    = S_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_sts  = STS_DONE;
                    n_out_fpos = FPOS_W'(r_cmp_idx);
                    n_out_cnt  = CNT_W'(r_occ);
                end else if (!w_re && !r_cmp_vld) begin
                    n_state    = S_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_sts  = STS_NOTFOUND;
                    n_out_fpos = NONE_POS;
                    n_out_cnt  = CNT_W'(r_occ);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_scan     <= n_scan;
        r_cmp_idx  <= n_cmp_idx;
        r_out_sts  <= n_out_sts;
        r_out_fpos <= n_out_fpos;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_cnt, r_out_fpos};
    assign o_m_tuser  = r_out_sts;

endmodule

@@ rtl/core/sfq_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
`timescale 1ns / 1ps

module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sfq_checker.sv @@
// ============================================================================
// Searchable FIFO queue checker
// Port-level checks on results and reset, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "searchable_fifo_queue_macros.svh"

module sfq_checker
    import sfq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // A stalled result keeps its transfer offered.
    `SFQ_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // No result is offered right after reset.
    `SFQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "result after reset")

    // A dropped push is only reported with a full queue.
    `SFQ_ASSERT(a_full_count, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser == STS_FULL |-> o_m_tdata[13:7] == CNT_W'(DEPTH),
        "full status with room left")

    // A reported match always carries the done status.
    `SFQ_ASSERT(a_match_done, i_clk, i_rst_n,
        o_m_tvalid && o_m_tdata[6:0] != NONE_POS |-> o_m_tuser == STS_DONE,
        "match with bad status")

    // A miss never carries a position.
    `SFQ_ASSERT(a_miss_none, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser == STS_NOTFOUND |-> o_m_tdata[6:0] == NONE_POS,
        "miss with a position")

endmodule

bind searchable_fifo_queue sfq_checker #(.DEPTH(DEPTH)) u_sfq_checker (.*);
